// File: design/acc_dp_pkg.sv
// acc_dp_pkg: shared codes, types and helpers for the accumulator machine datapath
// no dependencies; imported by accumulator_datapath_cycle_top
package acc_dp_pkg;

  typedef logic [1:0]  kind_t;
  typedef logic [15:0] sigset_t;
  typedef logic [2:0]  target_t;

  // request kinds
  localparam kind_t KIND_RUN        = 2'd0;
  localparam kind_t KIND_PRESET_REG = 2'd1;
  localparam kind_t KIND_PRESET_MEM = 2'd2;

  // preset targets
  localparam target_t TGT_A  = 3'd0;
  localparam target_t TGT_AK = 3'd1;
  localparam target_t TGT_L  = 3'd2;
  localparam target_t TGT_I  = 3'd3;
  localparam target_t TGT_S  = 3'd4;

  // control signal bit positions
  localparam int SIG_IL    = 0;
  localparam int SIG_WEL   = 1;
  localparam int SIG_WYL   = 2;
  localparam int SIG_WYAD  = 3;
  localparam int SIG_WEI   = 4;
  localparam int SIG_WEAK  = 5;
  localparam int SIG_DOD   = 6;
  localparam int SIG_ODE   = 7;
  localparam int SIG_PRZEP = 8;
  localparam int SIG_WYAK  = 9;
  localparam int SIG_WEJA  = 10;
  localparam int SIG_WEA   = 11;
  localparam int SIG_CZYT  = 12;
  localparam int SIG_PISZ  = 13;
  localparam int SIG_WES   = 14;
  localparam int SIG_WYS   = 15;

  localparam int SIGSET_W = 16;
  localparam int TARGET_W = 3;

  // pairs that fight over a bus, a latch or the memory port
  function automatic logic conflicting(input sigset_t s);
    logic [1:0] ops;
    ops = 2'(s[SIG_DOD]) + 2'(s[SIG_ODE]) + 2'(s[SIG_PRZEP]);
    return (s[SIG_CZYT] & s[SIG_PISZ]) | (s[SIG_WYAK] & s[SIG_WYS]) |
           (s[SIG_IL] & s[SIG_WEL]) | (s[SIG_WYL] & s[SIG_WYAD]) | (ops > 2'd1);
  endfunction

endpackage

// File: design/accumulator_datapath_cycle_top.sv
// accumulator_datapath_cycle_top: one machine cycle of an accumulator computer per request
// depends on acc_dp_pkg and acc_dp_ram
//
// Each request on the in_ stream either runs one machine clock cycle from a 16-bit set of
// control signals (tuser kind run), presets one register (kind preset register) or presets
// one memory word (kind preset memory). Every request yields exactly one result on the out_
// stream: all registers and both held buses after the step, and a rejected flag set when
// the control set held a conflicting pair (such a set changes nothing). A request is taken
// into an input register and worked out, once the result register is free, by one pass of
// short logic into the state and result registers; one request is taken every clock while
// out_ is not stalled, and its result reaches out_ through the input and result registers.
// The 8-bit add or subtract and the bus muxes set the clock. Main memory is a ram of
// 2^ADDR_BITS words; its read at address register A is issued ahead, with a bypass for a
// write in the same cycle. Per-word valid bits, cleared at reset, make memory read as zero
// until written, so there is no clearing pass and requests are taken right after reset.
module accumulator_datapath_cycle_top #(
  parameter int ADDR_BITS = 5,
  parameter int DATA_BITS = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // in_tdata from bit 0: signal_set, preset_target, preset_value, preset_address, zero fill
  input  logic [((acc_dp_pkg::SIGSET_W + acc_dp_pkg::TARGET_W + DATA_BITS + ADDR_BITS + 7)
                 / 8) * 8 - 1:0] in_tdata,
  // in_tuser: kind
  input  acc_dp_pkg::kind_t      in_tuser,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // out_tdata from bit 0: address_reg, data_reg, instr_reg, counter_reg, acc_reg,
  // alu_in_reg, addr_bus_val, data_bus_val, zero fill
  output logic [((3 * ADDR_BITS + 5 * DATA_BITS + 7) / 8) * 8 - 1:0] out_tdata,
  // out_tuser: rejected
  output logic                   out_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready
);
  import acc_dp_pkg::*;

  localparam int OUT_TDATA_W = ((3 * ADDR_BITS + 5 * DATA_BITS + 7) / 8) * 8;
  localparam int TGT_LO      = SIGSET_W;
  localparam int VAL_LO      = TGT_LO + TARGET_W;
  localparam int ADR_LO      = VAL_LO + DATA_BITS;
  localparam int MEM_DEPTH   = 2 ** ADDR_BITS;
  localparam logic [ADDR_BITS-1:0] COUNT_STEP = ADDR_BITS'(1);

  // input register
  logic                 in_vld_r;
  kind_t                in_kind_r;
  sigset_t              in_sig_r;
  target_t              in_tgt_r;
  logic [DATA_BITS-1:0] in_val_r;
  logic [ADDR_BITS-1:0] in_adr_r;

  // machine state
  logic [ADDR_BITS-1:0] a_r, a_nxt;
  logic [DATA_BITS-1:0] s_r, s_nxt;
  logic [DATA_BITS-1:0] i_r, i_nxt;
  logic [ADDR_BITS-1:0] l_r, l_nxt;
  logic [DATA_BITS-1:0] ak_r, ak_nxt;
  logic [DATA_BITS-1:0] j_r, j_nxt;
  logic [ADDR_BITS-1:0] abus_r, abus_nxt;
  logic [DATA_BITS-1:0] dbus_r, dbus_nxt;

  // memory side
  logic [MEM_DEPTH-1:0] valid_r;
  logic                 mem_we;
  logic [ADDR_BITS-1:0] mem_waddr;
  logic [DATA_BITS-1:0] mem_wdata;
  logic [ADDR_BITS-1:0] rd_addr;
  logic [DATA_BITS-1:0] ram_q;
  logic                 rd_valid_r;
  logic                 byp_hit_r;
  logic [DATA_BITS-1:0] byp_data_r;
  logic [DATA_BITS-1:0] mem_word;

  // output register
  logic                   out_vld_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic                   out_rej_r;

  logic fire;
  logic is_run;
  logic conflict;
  logic run_ok;

  assign fire      = in_vld_r & (~out_vld_r | out_tready);
  assign in_tready = ~in_vld_r | fire;
  assign is_run    = (in_kind_r == KIND_RUN);
  assign conflict  = conflicting(in_sig_r);
  assign run_ok    = is_run & ~conflict;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_vld_r <= 1'b1;
    end else if (fire) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_kind_r <= in_tuser;
      in_sig_r  <= in_tdata[SIGSET_W-1:0];
      in_tgt_r  <= in_tdata[VAL_LO-1:TGT_LO];
      in_val_r  <= in_tdata[ADR_LO-1:VAL_LO];
      in_adr_r  <= in_tdata[ADR_LO+ADDR_BITS-1:ADR_LO];
    end
  end

  // word at address A as it stands this cycle
  assign mem_word = byp_hit_r ? byp_data_r : (rd_valid_r ? ram_q : '0);

  // one machine step: buses first, then all latches from the old values
  always_comb begin
    a_nxt    = a_r;
    s_nxt    = s_r;
    i_nxt    = i_r;
    l_nxt    = l_r;
    ak_nxt   = ak_r;
    j_nxt    = j_r;
    abus_nxt = abus_r;
    dbus_nxt = dbus_r;
    if (run_ok) begin
      if (in_sig_r[SIG_WYL])  abus_nxt = l_r;
      if (in_sig_r[SIG_WYAD]) abus_nxt = i_r[ADDR_BITS-1:0];
      if (in_sig_r[SIG_WYAK]) dbus_nxt = ak_r;
      if (in_sig_r[SIG_WYS])  dbus_nxt = s_r;

      if (in_sig_r[SIG_IL])   l_nxt = l_r + COUNT_STEP;
      if (in_sig_r[SIG_WEL])  l_nxt = abus_nxt;
      if (in_sig_r[SIG_WEI])  i_nxt = dbus_nxt;
      if (in_sig_r[SIG_WEA])  a_nxt = abus_nxt;
      if (in_sig_r[SIG_WEJA]) j_nxt = dbus_nxt;
      if (in_sig_r[SIG_WES])  s_nxt = dbus_nxt;
      // memory read wins over bus load
      if (in_sig_r[SIG_CZYT]) s_nxt = mem_word;

      // an operation overrides a plain load from JAML
      if (in_sig_r[SIG_DOD]) begin
        ak_nxt = ak_r + j_r;
      end else if (in_sig_r[SIG_ODE]) begin
        ak_nxt = ak_r - j_r;
      end else if (in_sig_r[SIG_PRZEP]) begin
        ak_nxt = dbus_nxt;
      end else if (in_sig_r[SIG_WEAK]) begin
        ak_nxt = j_r;
      end
    end else if (in_kind_r == KIND_PRESET_REG) begin
      case (in_tgt_r)
        TGT_A:   a_nxt  = in_val_r[ADDR_BITS-1:0];
        TGT_AK:  ak_nxt = in_val_r;
        TGT_L:   l_nxt  = in_val_r[ADDR_BITS-1:0];
        TGT_I:   i_nxt  = in_val_r;
        TGT_S:   s_nxt  = in_val_r;
        default: ;
      endcase
    end
  end

  // memory write: PISZ stores old S at old A, or a memory preset
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = a_r;
    mem_wdata = s_r;
    if (fire) begin
      if (run_ok && in_sig_r[SIG_PISZ]) begin
        mem_we = 1'b1;
      end else if (in_kind_r == KIND_PRESET_MEM) begin
        mem_we    = 1'b1;
        mem_waddr = in_adr_r;
        mem_wdata = in_val_r;
      end
    end
  end

  // read ahead at the address A will hold after this edge
  assign rd_addr = fire ? a_nxt : a_r;

  acc_dp_ram #(
    .WIDTH (DATA_BITS),
    .DEPTH (MEM_DEPTH)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
      byp_hit_r  <= 1'b0;
    end else begin
      if (mem_we) begin
        valid_r[mem_waddr] <= 1'b1;
      end
      rd_valid_r <= valid_r[rd_addr];
      byp_hit_r  <= mem_we & (mem_waddr == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    byp_data_r <= mem_wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r    <= '0;
      s_r    <= '0;
      i_r    <= '0;
      l_r    <= '0;
      ak_r   <= '0;
      j_r    <= '0;
      abus_r <= '0;
      dbus_r <= '0;
    end else if (fire) begin
      a_r    <= a_nxt;
      s_r    <= s_nxt;
      i_r    <= i_nxt;
      l_r    <= l_nxt;
      ak_r   <= ak_nxt;
      j_r    <= j_nxt;
      abus_r <= abus_nxt;
      dbus_r <= dbus_nxt;
    end
  end

  // result register, parts the result side from the input side
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (fire) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= OUT_TDATA_W'({dbus_nxt, abus_nxt, j_nxt, ak_nxt, l_nxt, i_nxt, s_nxt,
                                  a_nxt});
      out_rej_r  <= is_run & conflict;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_rej_r;

  // a rejected set leaves A, S, AK, L and both buses as they were
  assert property (@(posedge clk) disable iff (!rst_n)
    (fire && is_run && conflict) |=>
      (a_r == $past(a_r) && s_r == $past(s_r) && ak_r == $past(ak_r) &&
       l_r == $past(l_r) && abus_r == $past(abus_r) && dbus_r == $past(dbus_r)))
    else $error("rejected control set changed state");

  // presets never move the buses
  assert property (@(posedge clk) disable iff (!rst_n)
    (fire && (in_kind_r == KIND_PRESET_REG || in_kind_r == KIND_PRESET_MEM)) |=>
      ($stable(abus_r) && $stable(dbus_r) && $stable(j_r)))
    else $error("preset request changed a bus or JAML");

  // state only moves when a request is worked out
  assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> ($stable(a_r) && $stable(ak_r) && $stable(l_r) && $stable(s_r)))
    else $error("state changed without a request");

  // a result never holds a rejection for a preset request
  assert property (@(posedge clk) disable iff (!rst_n)
    (fire && !is_run) |=> !out_rej_r)
    else $error("preset request reported as rejected");

endmodule

// File: design/acc_dp_ram.sv
// acc_dp_ram: generic single-write, single-read ram with registered read data
// no dependencies; used for main memory of accumulator_datapath_cycle_top
module acc_dp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
